// File: hw/rtl/qpe_pkg.sv
//------------------------------------------------------------------------------
// qpe_pkg
// Shared types, character codes and helper functions for the Quoted-Printable
// encoder.
//------------------------------------------------------------------------------
`default_nettype none

package qpe_pkg;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_EQ    = 8'd61;
   localparam logic [7:0] LIMIT_RST  = 8'd76;

   localparam int unsigned MAX_OPS = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       eol;
   } op_type;

   typedef struct packed {
      op_type [MAX_OPS-1:0] ops;
      logic [1:0]           op_count;
      logic                 crlf;
      logic                 last;
   } job_type;

   typedef enum logic [2:0] {
      PH_OP,
      PH_SOFT_CR,
      PH_SOFT_LF,
      PH_BODY,
      PH_ESC_HI,
      PH_ESC_LO,
      PH_CR,
      PH_LF
   } phase_type;

   function automatic job_type push_op(job_type j, logic [7:0] c, logic eol);
      job_type r;
      r = j;
      r.ops[r.op_count] = '{data: c, eol: eol};
      r.op_count = r.op_count + 2'd1;
      return r;
   endfunction

   function automatic logic is_plain(logic [7:0] c, logic eol);
      return (c == CHAR_SPACE && !eol) ||
             (c >= 8'd37 && c <= 8'd60) ||
             (c >= 8'd62 && c <= 8'd63) ||
             (c >= 8'd65 && c <= 8'd90) ||
             (c == 8'd95) ||
             (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = 8'd48 + {4'd0, n};
      end else begin
         r = 8'd55 + {4'd0, n};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/quoted_printable_encoder.sv
//------------------------------------------------------------------------------
// quoted_printable_encoder
// Streaming Quoted-Printable encoder with soft line breaks.
//
// Input beats (req_) carry one plain byte and an end-of-input flag. Output
// beats (rsp_) carry one encoded byte each; rsp_run_last marks the final byte
// caused by one input beat. A beat that only fills the lookahead produces no
// output beats. csr_line_limit is written when csr_write_enable is high.
//
// One input beat is turned into a short job (up to three characters to encode
// plus an optional CR LF) in the cycle it is accepted. The emitter sends one
// byte per cycle while the receiver does not stall: a verbatim byte is one
// output byte, an escape three, a soft break three more. The first output
// byte of a job passes through the job register and then the output register.
// A new input beat is taken in the cycle the current job's last byte enters
// the output register, so jobs run back to back.
// Reset clears the lookahead, line count and both valid flags, and restores
// the line limit to 76. When the receiver stalls, the output register holds
// its byte and the emitter and input side stall behind it.
//------------------------------------------------------------------------------
`default_nettype none

module quoted_printable_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_line_limit,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_input,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_run_last
);

   logic [7:0]          line_limit_ff;
   logic [7:0]          line_count_ff, line_count_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;
   logic                cr_pending_ff, cr_pending_in;
   qpe_pkg::job_type    job_ff, job_in;
   logic                job_valid_ff;
   qpe_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]          op_idx_ff, op_idx_in;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                advance;
   logic                job_end;
   logic                job_has_out;
   qpe_pkg::op_type     cur_op;
   logic                cur_plain;
   logic                soft_break;
   logic [9:0]          next_count;
   logic [9:0]          limit_now;
   logic                op_done;
   logic                more_ops;

   assign accept  = req_valid && !req_stall;
   assign advance = job_valid_ff && (!rsp_valid_ff || !rsp_stall);

   // build the job for the incoming beat and the new lookahead state
   always_comb begin
      job_in        = '0;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      cr_pending_in = cr_pending_ff;
      job_in.last   = req_end_of_input;
      if (cr_pending_ff) begin
         cr_pending_in = 1'b0;
         if (req_data_byte == qpe_pkg::CHAR_LF) begin
            if (held_valid_ff) begin
               job_in = qpe_pkg::push_op(job_in, held_byte_ff, 1'b1);
            end
            held_valid_in = 1'b0;
            job_in.crlf   = 1'b1;
         end else begin
            if (held_valid_ff) begin
               job_in = qpe_pkg::push_op(job_in, held_byte_ff, 1'b0);
            end
            held_byte_in  = qpe_pkg::CHAR_CR;
            held_valid_in = 1'b1;
            if (req_data_byte == qpe_pkg::CHAR_CR) begin
               cr_pending_in = 1'b1;
            end else begin
               job_in = qpe_pkg::push_op(job_in, qpe_pkg::CHAR_CR, 1'b0);
               held_byte_in = req_data_byte;
            end
         end
      end else if (req_data_byte == qpe_pkg::CHAR_CR) begin
         cr_pending_in = 1'b1;
      end else begin
         if (held_valid_ff) begin
            job_in = qpe_pkg::push_op(job_in, held_byte_ff, 1'b0);
         end
         held_byte_in  = req_data_byte;
         held_valid_in = 1'b1;
      end
      if (req_end_of_input) begin
         if (cr_pending_in) begin
            if (held_valid_in) begin
               job_in = qpe_pkg::push_op(job_in, held_byte_in, 1'b0);
            end
            job_in = qpe_pkg::push_op(job_in, qpe_pkg::CHAR_CR, 1'b1);
         end else if (held_valid_in) begin
            job_in = qpe_pkg::push_op(job_in, held_byte_in, 1'b1);
         end
         held_valid_in = 1'b0;
         cr_pending_in = 1'b0;
      end
   end

   assign job_has_out = (job_in.op_count != 2'd0) || job_in.crlf;

   // emitter: one output byte per advance
   assign cur_op     = job_ff.ops[op_idx_ff];
   assign cur_plain  = qpe_pkg::is_plain(cur_op.data, cur_op.eol);
   assign next_count = {2'b00, line_count_ff} + (cur_plain ? 10'd1 : 10'd3);
   assign limit_now  = cur_op.eol ? {2'b00, line_limit_ff}
                                  : {2'b00, line_limit_ff} - 10'd1;
   assign soft_break = $signed(next_count) > $signed(limit_now);
   assign more_ops   = ({1'b0, op_idx_ff} + 3'd1) < {1'b0, job_ff.op_count};

   always_comb begin
      rsp_byte_in   = qpe_pkg::CHAR_EQ;
      phase_in      = phase_ff;
      op_idx_in     = op_idx_ff;
      line_count_in = line_count_ff;
      op_done       = 1'b0;
      job_end       = 1'b0;
      unique case (phase_ff)
         qpe_pkg::PH_OP, qpe_pkg::PH_BODY: begin
            if (phase_ff == qpe_pkg::PH_OP && soft_break) begin
               rsp_byte_in = qpe_pkg::CHAR_EQ;
               phase_in    = qpe_pkg::PH_SOFT_CR;
            end else if (cur_plain) begin
               rsp_byte_in   = cur_op.data;
               line_count_in = line_count_ff + 8'd1;
               op_done       = 1'b1;
            end else begin
               rsp_byte_in = qpe_pkg::CHAR_EQ;
               phase_in    = qpe_pkg::PH_ESC_HI;
            end
         end
         qpe_pkg::PH_SOFT_CR: begin
            rsp_byte_in = qpe_pkg::CHAR_CR;
            phase_in    = qpe_pkg::PH_SOFT_LF;
         end
         qpe_pkg::PH_SOFT_LF: begin
            rsp_byte_in   = qpe_pkg::CHAR_LF;
            line_count_in = '0;
            phase_in      = qpe_pkg::PH_BODY;
         end
         qpe_pkg::PH_ESC_HI: begin
            rsp_byte_in = qpe_pkg::hex_char(cur_op.data[7:4]);
            phase_in    = qpe_pkg::PH_ESC_LO;
         end
         qpe_pkg::PH_ESC_LO: begin
            rsp_byte_in   = qpe_pkg::hex_char(cur_op.data[3:0]);
            line_count_in = line_count_ff + 8'd3;
            op_done       = 1'b1;
         end
         qpe_pkg::PH_CR: begin
            rsp_byte_in = qpe_pkg::CHAR_CR;
            phase_in    = qpe_pkg::PH_LF;
         end
         qpe_pkg::PH_LF: begin
            rsp_byte_in   = qpe_pkg::CHAR_LF;
            line_count_in = '0;
            job_end       = 1'b1;
         end
         default: begin
            job_end = 1'b1;
         end
      endcase
      if (op_done) begin
         if (more_ops) begin
            op_idx_in = op_idx_ff + 2'd1;
            phase_in  = qpe_pkg::PH_OP;
         end else if (job_ff.crlf) begin
            phase_in = qpe_pkg::PH_CR;
         end else begin
            job_end = 1'b1;
         end
      end
      if (job_end && job_ff.last) begin
         line_count_in = '0;
      end
      rsp_last_in = job_end;
   end

   assign req_stall = job_valid_ff && !(advance && job_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= qpe_pkg::LIMIT_RST;
         line_count_ff <= '0;
         held_valid_ff <= 1'b0;
         cr_pending_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= qpe_pkg::PH_OP;
         op_idx_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            line_limit_ff <= csr_line_limit;
         end
         if (accept) begin
            held_valid_ff <= held_valid_in;
            cr_pending_ff <= cr_pending_in;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            line_count_ff <= line_count_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && job_has_out) begin
            job_valid_ff <= 1'b1;
            op_idx_ff    <= '0;
            phase_ff     <= (job_in.op_count == 2'd0) ? qpe_pkg::PH_CR : qpe_pkg::PH_OP;
         end else if (advance) begin
            phase_ff  <= phase_in;
            op_idx_ff <= op_idx_in;
            if (job_end) begin
               job_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= held_byte_in;
         if (job_has_out) begin
            job_ff <= job_in;
         end
      end
      if (advance) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   a_crlf_phase: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && (phase_ff == qpe_pkg::PH_CR || phase_ff == qpe_pkg::PH_LF)
      |-> job_ff.crlf)
      else $error("CR LF phase in a job without line end");

   a_op_index: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !(phase_ff == qpe_pkg::PH_CR || phase_ff == qpe_pkg::PH_LF)
      |-> op_idx_ff < job_ff.op_count)
      else $error("op index beyond job length");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !job_valid_ff |-> !req_stall)
      else $error("input stalled with no job in flight");

   a_reset_count: assert property (@(posedge clock)
      reset |=> line_count_ff == 8'd0 && !rsp_valid)
      else $error("line count or output valid not cleared by reset");

endmodule

`default_nettype wire
